// File: src/gdrc_pkg.sv
`timescale 1ns / 1ps
package gdrc_pkg;
	localparam logic [14:0] ONE_Q14 = 15'd16384;
	localparam logic [14:0] SIN_A = 15'd25736;
	localparam logic [14:0] SIN_B = 15'd10512;
	localparam logic [14:0] SIN_C = 15'd1160;
	localparam logic [11:0] CELL_Q11 = 12'd2048;
	localparam logic [15:0] MAXD_RESET = 16'd51200;

	// operation field of an input transaction
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST = 1'b1;

	typedef struct packed {
		logic start;
		logic [16:0] num;
		logic [14:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [15:0] quo;
	} div_rsp_t;
endpackage

// File: src/gdrc_if.sv
`timescale 1ns / 1ps
interface gdrc_in_if #(
	parameter int ANGLE_BITS = 12
);
	logic valid;
	logic ready;
	logic operation;
	logic [3:0] cell_x;
	logic [3:0] cell_z;
	logic cell_is_wall;
	logic [14:0] pos_x;
	logic [14:0] pos_z;
	logic [ANGLE_BITS-1:0] heading;
	modport source(output valid, operation, cell_x, cell_z, cell_is_wall, pos_x, pos_z,
		heading, input ready);
	modport sink(input valid, operation, cell_x, cell_z, cell_is_wall, pos_x, pos_z,
		heading, output ready);
endinterface

interface gdrc_out_if;
	logic valid;
	logic ready;
	logic [15:0] hit_distance;
	logic hit_side;
	logic wall_hit;
	modport source(output valid, hit_distance, hit_side, wall_hit, input ready);
	modport sink(input valid, hit_distance, hit_side, wall_hit, output ready);
endinterface

// File: src/gdrc_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle; quotient saturates to 16 bits.
module gdrc_div (
	input logic clk,
	input logic arst_n,
	input gdrc_pkg::div_req_t req,
	output gdrc_pkg::div_rsp_t rsp
);
	// numerator is hitn*16384 : 17+14 = 31 bits
	logic [30:0] num_q;
	logic [14:0] den_q;
	logic [15:0] rem_q;
	logic [30:0] quo_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [15:0] trial;

	assign trial = {rem_q[14:0], num_q[30]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd30;
				num_q <= {req.num, 14'd0};
				den_q <= req.den;
				rem_q <= '0;
				quo_q <= '0;
			end else if (busy_q) begin
				num_q <= {num_q[29:0], 1'b0};
				if (trial >= {1'b0, den_q}) begin
					rem_q <= trial - {1'b0, den_q};
					quo_q <= {quo_q[29:0], 1'b1};
				end else begin
					rem_q <= trial;
					quo_q <= {quo_q[29:0], 1'b0};
				end
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo = (|quo_q[30:16]) ? 16'hFFFF : quo_q[15:0];
endmodule

// File: src/gdrc_core.sv
`timescale 1ns / 1ps
// Sequencer: quarter-wave sine through one shared 16x16 multiplier, DDA walk with
// one compare per step against a registered map read, wall-hit distance through the
// divider (max_distance when the walk leaves the grid or runs out of steps). A
// clearing pass over all GRID_WIDTH*GRID_HEIGHT cells opens the map after reset.
module gdrc_core #(
	parameter int GRID_WIDTH = 16,
	parameter int GRID_HEIGHT = 16,
	parameter int ANGLE_BITS = 12
) (
	input logic clk,
	input logic arst_n,
	input logic [15:0] max_distance,
	gdrc_in_if.sink in_ch,
	gdrc_out_if.source out_ch
);
	localparam int XW = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
	localparam int ZW = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
	localparam int CW = 10;
	localparam int STEP_LIMIT = 2 * (GRID_WIDTH + GRID_HEIGHT) + 64;
	localparam int SW = $clog2(STEP_LIMIT + 1);
	localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
	localparam int AW = $clog2(DEPTH);
	// boundary distance in Q11 cells; never narrower than the divider numerator
	localparam int NW_G = 11 + $clog2(GRID_WIDTH + GRID_HEIGHT + 2);
	localparam int NW = (NW_G > 17) ? NW_G : 17;
	localparam int PW = NW + 15;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_SIN_X2, S_SIN_IN, S_SIN_MID, S_SIN_S,
		S_STEP, S_CHK, S_DIV, S_OUT
	} state_t;

	state_t state_q;
	logic map_mem [DEPTH];
	logic map_rd_q;
	logic [AW-1:0] clr_q;
	logic [14:0] pos_x_q, pos_z_q;
	logic [15:0] phase_q;
	logic axis_q; // 0: x component (sin), 1: z component
	logic [14:0] x2_q, t_q;
	logic [14:0] ax_q, az_q;
	logic dxn_q, dzn_q;
	logic signed [CW-1:0] cx_q, cz_q;
	logic [NW-1:0] nx_q, nz_q, hitn_q;
	logic side_q;
	logic [SW-1:0] n_q;
	logic [15:0] dist_q;
	logic hs_q, wh_q, ov_q;
	logic [15:0] ma, mb;
	logic [31:0] mp, mr;
	logic [15:0] ph2;
	logic [14:0] qx;
	logic [14:0] s_clamp;
	logic dxn_now, dzn_now;
	logic takex;
	logic [PW-1:0] px_prod, pz_prod;
	logic signed [CW-1:0] step_cx, step_cz;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] waddr;
	logic wr_in_range;
	logic in_accept;
	logic mem_we;
	logic [AW-1:0] mem_waddr;
	logic mem_wdata;
	logic inside_g;
	logic [14:0] den;
	gdrc_pkg::div_req_t dreq;
	gdrc_pkg::div_rsp_t drsp;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_accept = in_ch.valid && in_ch.ready;
	assign out_ch.valid = ov_q;
	assign out_ch.hit_distance = dist_q;
	assign out_ch.hit_side = hs_q;
	assign out_ch.wall_hit = wh_q;

	// shared multiplier with Q14 round-half-up
	always_comb begin
		unique case (state_q)
			S_SIN_X2: begin ma = {1'b0, qx}; mb = {1'b0, qx}; end
			S_SIN_IN: begin ma = {1'b0, x2_q}; mb = {1'b0, gdrc_pkg::SIN_C}; end
			S_SIN_MID: begin ma = {1'b0, x2_q}; mb = {1'b0, t_q}; end
			S_SIN_S: begin ma = {1'b0, qx}; mb = {1'b0, t_q}; end
			default: begin ma = '0; mb = '0; end
		endcase
	end
	assign mp = 32'(ma) * 32'(mb);
	assign mr = (mp + 32'd8192) >> 14;

	assign ph2 = axis_q ? (phase_q + 16'h4000) : phase_q;
	assign qx = ph2[14] ? (gdrc_pkg::ONE_Q14 - {1'b0, ph2[13:0]}) : {1'b0, ph2[13:0]};
	assign s_clamp = (mr > 32'd16384) ? gdrc_pkg::ONE_Q14 : mr[14:0];
	// dx = sine(phase); dz = -sine(phase + quarter turn)
	assign dxn_now = ph2[15] && (s_clamp != '0);
	assign dzn_now = !ph2[15] && (s_clamp != '0);

	// zero component never wins: its product side is zero, the other is not
	assign px_prod = PW'(nx_q) * PW'(az_q);
	assign pz_prod = PW'(nz_q) * PW'(ax_q);
	assign takex = (px_prod < pz_prod);

	assign step_cx = takex ? (dxn_q ? cx_q - CW'(1) : cx_q + CW'(1)) : cx_q;
	assign step_cz = takex ? cz_q : (dzn_q ? cz_q - CW'(1) : cz_q + CW'(1));
	assign rd_addr = AW'(AW'(step_cz[ZW-1:0]) * AW'(GRID_WIDTH)) + AW'(step_cx[XW-1:0]);

	assign inside_g = (cx_q >= 0) && (cx_q < CW'(GRID_WIDTH)) && (cz_q >= 0)
		&& (cz_q < CW'(GRID_HEIGHT));

	assign wr_in_range = (int'(in_ch.cell_x) < GRID_WIDTH)
		&& (int'(in_ch.cell_z) < GRID_HEIGHT);
	assign waddr = AW'(AW'(in_ch.cell_z) * AW'(GRID_WIDTH)) + AW'(in_ch.cell_x);
	assign mem_we = (state_q == S_CLEAR)
		|| (in_accept && (in_ch.operation == gdrc_pkg::OP_WRITE) && wr_in_range);
	assign mem_waddr = (state_q == S_CLEAR) ? clr_q : waddr;
	assign mem_wdata = (state_q == S_CLEAR) ? 1'b0 : in_ch.cell_is_wall;

	// wall map, registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			map_mem[mem_waddr] <= mem_wdata;
		map_rd_q <= map_mem[rd_addr];
	end

	assign den = side_q ? az_q : ax_q;
	assign dreq.start = (state_q == S_CHK) && inside_g && map_rd_q && (den != '0);
	// a numerator past 17 bits saturates the quotient either way
	assign dreq.num = (hitn_q > NW'(17'h1FFFF)) ? 17'h1FFFF : hitn_q[16:0];
	assign dreq.den = den;

	gdrc_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			ov_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_accept && (in_ch.operation == gdrc_pkg::OP_CAST)) begin
						pos_x_q <= in_ch.pos_x;
						pos_z_q <= in_ch.pos_z;
						phase_q <= 16'({in_ch.heading, 16'd0} >> ANGLE_BITS);
						axis_q <= 1'b0;
						state_q <= S_SIN_X2;
					end
				end
				S_SIN_X2: begin
					x2_q <= mr[14:0];
					state_q <= S_SIN_IN;
				end
				S_SIN_IN: begin
					t_q <= gdrc_pkg::SIN_B - mr[14:0];
					state_q <= S_SIN_MID;
				end
				S_SIN_MID: begin
					t_q <= gdrc_pkg::SIN_A - mr[14:0];
					state_q <= S_SIN_S;
				end
				S_SIN_S: begin
					if (!axis_q) begin
						ax_q <= s_clamp;
						dxn_q <= dxn_now;
						axis_q <= 1'b1;
						state_q <= S_SIN_X2;
					end else begin
						az_q <= s_clamp;
						dzn_q <= dzn_now;
						nx_q <= dxn_q ? NW'(pos_x_q[10:0])
							: NW'(gdrc_pkg::CELL_Q11) - NW'(pos_x_q[10:0]);
						nz_q <= dzn_now ? NW'(pos_z_q[10:0])
							: NW'(gdrc_pkg::CELL_Q11) - NW'(pos_z_q[10:0]);
						cx_q <= CW'(pos_x_q[14:11]);
						cz_q <= CW'(pos_z_q[14:11]);
						n_q <= '0;
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					if (n_q == SW'(STEP_LIMIT)) begin
						dist_q <= max_distance; hs_q <= 1'b0; wh_q <= 1'b0;
						ov_q <= 1'b1; state_q <= S_OUT;
					end else begin
						n_q <= n_q + 1'b1;
						cx_q <= step_cx;
						cz_q <= step_cz;
						if (takex) begin
							hitn_q <= nx_q; nx_q <= nx_q + NW'(gdrc_pkg::CELL_Q11);
							side_q <= 1'b0;
						end else begin
							hitn_q <= nz_q; nz_q <= nz_q + NW'(gdrc_pkg::CELL_Q11);
							side_q <= 1'b1;
						end
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (!inside_g) begin
						dist_q <= max_distance; hs_q <= 1'b0; wh_q <= 1'b0;
						ov_q <= 1'b1; state_q <= S_OUT;
					end else if (map_rd_q) begin
						hs_q <= side_q; wh_q <= 1'b1;
						if (den != '0) state_q <= S_DIV;
						else begin dist_q <= 16'hFFFF; ov_q <= 1'b1; state_q <= S_OUT; end
					end else
						state_q <= S_STEP;
				end
				S_DIV: begin
					if (drsp.done) begin
						dist_q <= drsp.quo; ov_q <= 1'b1; state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_ch.ready) begin
						ov_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	property p_busy_not_ready;
		@(posedge clk) disable iff (!arst_n) (state_q != S_IDLE) |-> !in_ch.ready;
	endproperty
	a_busy: assert property (p_busy_not_ready) else $error("ready while busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.hit_distance)))
		else $error("result changed while stalled");
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> (state_q == S_DIV)) else $error("stray divide");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (state_q == S_OUT)) else $error("result outside output state");
endmodule

// File: src/grid_dda_ray_cast_core.sv
`timescale 1ns / 1ps
// Map writes are taken back to back while idle. A cast runs the sine states
// (S_SIN_X2, S_SIN_IN, S_SIN_MID, S_SIN_S) once per axis, then S_STEP and S_CHK for
// each DDA step, then on a wall hit the divider, before its result is offered.
// Only one cast is in flight at a time; the next transaction is taken after the
// result is accepted. Reset: a pass over GRID_WIDTH*GRID_HEIGHT cells clears the
// map with ready low; max_distance resets to 51200.
module grid_dda_ray_cast_core #(
	parameter int GRID_WIDTH = 16,
	parameter int GRID_HEIGHT = 16,
	parameter int ANGLE_BITS = 12
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [15:0] cfg_wdata,
	gdrc_in_if.sink in_ch,
	gdrc_out_if.source out_ch
);
	logic [15:0] max_distance_q;

	// max distance register; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_distance_q <= gdrc_pkg::MAXD_RESET;
		end else if (cfg_we) begin
			max_distance_q <= cfg_wdata;
		end
	end

	gdrc_core #(
		.GRID_WIDTH(GRID_WIDTH),
		.GRID_HEIGHT(GRID_HEIGHT),
		.ANGLE_BITS(ANGLE_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.max_distance(max_distance_q),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	localparam int GRID_WIDTH = 16;
	localparam int GRID_HEIGHT = 16;
	localparam int ANGLE_BITS = 12;
	localparam int STEP_LIMIT = 2 * (GRID_WIDTH + GRID_HEIGHT) + 64;
	// no-accept watchdog; covers slow casts, receiver stall bursts and the long hold-off
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [15:0] distance;
		logic side;
		logic hit;
	} ray_hit_t;

	// Ray predictor plus queue of pending hits.
	class ray_scoreboard;
		bit wall_map [GRID_HEIGHT*GRID_WIDTH];
		logic [15:0] exit_distance;
		ray_hit_t pending[$];
		int errors;

		function void clear();
			foreach (wall_map[i]) wall_map[i] = 1'b0;
			exit_distance = gdrc_pkg::MAXD_RESET;
			pending.delete();
			errors = 0;
		endfunction

		function automatic longint quarter_sine(longint x);
			longint x2, inner, mid, s;
			x2 = (x * x + 8192) >>> 14;
			inner = 10512 - ((x2 * 1160 + 8192) >>> 14);
			mid = 25736 - ((x2 * inner + 8192) >>> 14);
			s = (x * mid + 8192) >>> 14;
			if (s > 16384) s = 16384;
			return s;
		endfunction

		function automatic longint sine_q14(logic [15:0] phase);
			logic [1:0] quad;
			longint t, s;
			quad = phase[15:14];
			t = phase[13:0];
			s = quarter_sine(quad[0] ? 16384 - t : t);
			return quad[1] ? -s : s;
		endfunction

		// note an accepted transaction; a cast queues its predicted hit
		function void note_input(logic op, logic [3:0] wx, logic [3:0] wz, logic wv,
			logic [14:0] px, logic [14:0] pz, logic [ANGLE_BITS-1:0] ang);
			logic [15:0] phase;
			longint dx, dz, ax, az, nx, nz, hitn, hit_len;
			int cx, cz, sx, sz, side;
			ray_hit_t r;
			bit done;
			if (op == gdrc_pkg::OP_WRITE) begin
				wall_map[wz*GRID_WIDTH + wx] = wv;
				return;
			end
			phase = 16'(ang) << (16 - ANGLE_BITS);
			dx = sine_q14(phase);
			dz = -sine_q14(phase + 16'h4000);
			ax = dx < 0 ? -dx : dx;
			az = dz < 0 ? -dz : dz;
			cx = px >> 11;
			cz = pz >> 11;
			sx = dx < 0 ? -1 : 1;
			sz = dz < 0 ? -1 : 1;
			nx = dx < 0 ? px[10:0] : 2048 - px[10:0];
			nz = dz < 0 ? pz[10:0] : 2048 - pz[10:0];
			r = '{distance: exit_distance, side: 1'b0, hit: 1'b0};
			done = 0;
			for (int n = 0; n < STEP_LIMIT && !done; n++) begin
				// ties go to the z boundary
				if (nx * az < nz * ax) begin
					hitn = nx; nx += 2048; cx += sx; side = 0;
				end else begin
					hitn = nz; nz += 2048; cz += sz; side = 1;
				end
				if (cx < 0 || cx >= GRID_WIDTH || cz < 0 || cz >= GRID_HEIGHT)
					done = 1;
				else if (wall_map[cz*GRID_WIDTH + cx]) begin
					hit_len = 65535;
					if ((side ? az : ax) != 0) begin
						hit_len = (hitn * 16384) / (side ? az : ax);
						if (hit_len > 65535) hit_len = 65535;
					end
					r = '{distance: 16'(hit_len), side: 1'(side), hit: 1'b1};
					done = 1;
				end
			end
			pending.push_back(r);
		endfunction

		function void check_result(ray_hit_t got);
			ray_hit_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result distance=%0d side=%0d hit=%0d", $time,
					got.distance, got.side, got.hit);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.distance !== want.distance) begin
				$display("%0t: hit_distance expected %0d actual %0d", $time, want.distance,
					got.distance);
				errors++;
			end
			if (got.side !== want.side) begin
				$display("%0t: hit_side expected %0d actual %0d", $time, want.side, got.side);
				errors++;
			end
			if (got.hit !== want.hit) begin
				$display("%0t: wall_hit expected %0d actual %0d", $time, want.hit, got.hit);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	gdrc_in_if #(.ANGLE_BITS(ANGLE_BITS)) in_ch();
	gdrc_out_if out_ch();

	grid_dda_ray_cast_core #(
		.GRID_WIDTH(GRID_WIDTH),
		.GRID_HEIGHT(GRID_HEIGHT),
		.ANGLE_BITS(ANGLE_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	always #1 clk = ~clk;

	ray_scoreboard sb;
	bit sender_gaps = 1;    // idle bursts on the input side
	bit receiver_gaps = 1;  // stall bursts on the output side
	bit hold_off = 0;       // long receiver stall request
	int idle_cycles = 0;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.operation = gdrc_pkg::OP_WRITE;
		in_ch.cell_x = '0;
		in_ch.cell_z = '0;
		in_ch.cell_is_wall = 1'b0;
		in_ch.pos_x = '0;
		in_ch.pos_z = '0;
		in_ch.heading = '0;
		out_ch.ready = 1'b0;
	end

	// Result side: random stall bursts, an optional long hold-off, check on accept.
	initial begin : result_side
		int burst;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ch.ready <= 1'b0;
				repeat (600) @(negedge clk);
				hold_off = 0;
				out_ch.ready <= 1'b1;
			end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 16);
				out_ch.ready <= 1'b0;
				repeat (burst - 1) @(negedge clk);
			end else
				out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_result('{distance: out_ch.hit_distance, side: out_ch.hit_side,
				hit: out_ch.wall_hit});
	end

	// Watchdog: cycles without any accepted transaction on either side.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[grid_dda_ray_cast_core] ERROR");
			$finish;
		end
	end

	// Offer one transaction; it is noted in the scoreboard when accepted.
	task automatic send_item(logic op, logic [3:0] wx, logic [3:0] wz, logic wv,
		logic [14:0] px, logic [14:0] pz, logic [ANGLE_BITS-1:0] ang);
		if (sender_gaps && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.operation <= op;
		in_ch.cell_x <= wx;
		in_ch.cell_z <= wz;
		in_ch.cell_is_wall <= wv;
		in_ch.pos_x <= px;
		in_ch.pos_z <= pz;
		in_ch.heading <= ang;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_input(op, wx, wz, wv, px, pz, ang);
		@(negedge clk);
	endtask

	task automatic write_cell(int wx, int wz, bit wv);
		send_item(gdrc_pkg::OP_WRITE, 4'(wx), 4'(wz), wv, 15'($urandom), 15'($urandom),
			ANGLE_BITS'($urandom));
	endtask

	task automatic fire_ray(logic [14:0] px, logic [14:0] pz, logic [ANGLE_BITS-1:0] ang);
		send_item(gdrc_pkg::OP_CAST, 4'($urandom), 4'($urandom), 1'($urandom), px, pz, ang);
	endtask

	// Drain pending hits, wait out any tail of the walk, then reprogram max_distance.
	task automatic set_max_distance(logic [15:0] value);
		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (150) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		sb.exit_distance = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Border walls on every side of the grid, then random interior cells set to wall or open.
	task automatic build_arena(int density);
		for (int i = 0; i < GRID_WIDTH; i++) begin
			write_cell(i, 0, 1);
			write_cell(i, GRID_HEIGHT - 1, 1);
		end
		for (int i = 1; i < GRID_HEIGHT - 1; i++) begin
			write_cell(0, i, 1);
			write_cell(GRID_WIDTH - 1, i, 1);
		end
		for (int i = 0; i < density; i++)
			write_cell($urandom_range(1, 14), $urandom_range(1, 14), $urandom_range(0, 1));
	endtask

	task automatic random_phase(int count, int wall_pct);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < wall_pct)
				write_cell($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 1));
			else if ($urandom_range(0, 7) == 0)
				// axis-aligned and diagonal headings hit the zero-component and tie cases
				fire_ray(15'($urandom), 15'($urandom),
					ANGLE_BITS'($urandom_range(0, 7) << (ANGLE_BITS - 3)));
			else
				fire_ray(15'($urandom), 15'($urandom), ANGLE_BITS'($urandom));
		end
	endtask

	initial begin : stimulus
		sb = new();
		sb.clear();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty map leaves the grid at the reset max_distance.
		fire_ray(15'd0, 15'd0, '0);
		fire_ray(15'h7FFF, 15'h7FFF, '1);
		fire_ray(15'h4000, 15'h4000, ANGLE_BITS'(1 << (ANGLE_BITS - 2)));
		// walls around the center cell (8,8)
		write_cell(8, 7, 1);
		write_cell(9, 8, 1);
		write_cell(8, 9, 1);
		write_cell(7, 8, 1);
		// facing -z, +x, +z, -x from cell center: zero components on the other axis
		for (int q = 0; q < 4; q++)
			fire_ray(15'h4400, 15'h4400, ANGLE_BITS'(q << (ANGLE_BITS - 2)));
		// exact diagonal from a corner: equal side distances
		fire_ray(15'h4000, 15'h4000, ANGLE_BITS'(1 << (ANGLE_BITS - 3)));
		fire_ray(15'h4000, 15'h4000, ANGLE_BITS'(3 << (ANGLE_BITS - 3)));
		// fraction edges: on a boundary and just below the next
		fire_ray(15'h47FF, 15'h4400, ANGLE_BITS'(1 << (ANGLE_BITS - 2)));
		fire_ray(15'h4400, 15'h4000, '0);
		// origin inside the wall cell (7,8), facing +x
		fire_ray(15'h3C00, 15'h4400, ANGLE_BITS'(1 << (ANGLE_BITS - 2)));
		write_cell(15, 15, 1);
		write_cell(8, 7, 0);
		fire_ray(15'h4400, 15'h4400, ANGLE_BITS'(1));

		set_max_distance(16'd0);
		fire_ray(15'h0400, 15'h0400, '0);
		set_max_distance(16'hFFFF);
		fire_ray(15'h0400, 15'h0400, '0);
		set_max_distance(16'd12345);

		// Long hold-off: the block holds its result and stalls its input.
		hold_off = 1;
		random_phase(20, 0);

		// Random phases with varied map density and max_distance.
		build_arena(40);
		random_phase(300, 10);
		set_max_distance(16'($urandom));
		random_phase(300, 30);
		set_max_distance(gdrc_pkg::MAXD_RESET);
		for (int i = 0; i < 256; i++)
			write_cell(i % 16, i / 16, 1'b0);
		random_phase(200, 5);
		build_arena(10);
		// last stretch with no idling on either side
		sender_gaps = 0;
		receiver_gaps = 0;
		random_phase(300, 10);

		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (150) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("[grid_dda_ray_cast_core] OK");
		else
			$display("[grid_dda_ray_cast_core] ERROR");
		$finish;
	end
endmodule
